[rtl/md5_pkg.sv]
package md5_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int LEN_POS = 448 / 8;
  localparam int CHUNK_BYTES = 512 / 8;

  typedef enum logic [1:0] {
    BSEL_MSG  = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic       wr_en;
    byte_sel_t  wr_sel;
    logic [5:0] wr_addr;
    logic       cnt_inc;
    logic       rnd_start;
    logic       rnd_step;
    logic       rnd_finish;
    logic       restart;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } md5_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      2'd3: g = 4'(7 * i[3:0]);
      default: g = 4'd0;
    endcase
    return g;
  endfunction

endpackage

[rtl/md5_ctrl.sv]
module md5_ctrl import md5_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_has,
  input  logic       in_last,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_idx,
  input  md5_sts_t   sts,
  output md5_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [5:0] addr_r, addr_nxt;
  logic       fin_r, fin_nxt;
  logic       lenfill_r, lenfill_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       padded_once_r, padded_once_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_idx    = idx_r;

  always_comb begin
    logic [5:0] nf;
    state_nxt   = state_r;
    rnd_nxt     = rnd_r;
    addr_nxt    = addr_r;
    fin_nxt     = fin_r;
    lenfill_nxt = lenfill_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.wr_sel  = BSEL_MSG;
    nf          = sts.fill + 6'(in_has);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.wr_en   = in_has;
          cmd.wr_addr = sts.fill;
          cmd.cnt_inc = in_has;
          fin_nxt     = in_last;
          if (in_has && sts.fill == 6'(CHUNK_BYTES - 1)) begin
            cmd.rnd_start = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = S_RUN;
          end else if (in_last) begin
            addr_nxt    = nf;
            lenfill_nxt = 1'b0;
            state_nxt   = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = addr_r;
        if (lenfill_r)
          cmd.wr_sel = (addr_r >= 6'(LEN_POS)) ? BSEL_LEN : BSEL_ZERO;
        else if (addr_r == sts.fill)
          cmd.wr_sel = BSEL_PAD;
        else
          cmd.wr_sel = (addr_r >= 6'(LEN_POS) && sts.fill < 6'(LEN_POS)) ?
                       BSEL_LEN : BSEL_ZERO;
        addr_nxt = addr_r + 6'd1;
        if (addr_r == 6'(CHUNK_BYTES - 1)) begin
          cmd.rnd_start = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = S_RUN;
        end
      end
      S_RUN: begin
        cmd.rnd_step = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == 6'(CHUNK_BYTES - 1)) begin
          cmd.rnd_finish = 1'b1;
          if (!fin_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_OUT;
            idx_nxt   = '0;
          end
          if (fin_r && !lenfill_r && sts.fill >= 6'(LEN_POS) && addr_r == 6'd0
              && padded_once_r) begin
            state_nxt   = S_PAD;
            lenfill_nxt = 1'b1;
          end else if (fin_r && !padded_once_r) begin
            state_nxt   = S_PAD;
            addr_nxt    = sts.fill;
            lenfill_nxt = 1'b0;
          end
        end
      end
      S_OUT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            cmd.restart = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    padded_once_nxt = padded_once_r;
    if (state_r == S_PAD) padded_once_nxt = 1'b1;
    if (state_r == S_IDLE) padded_once_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rnd_r         <= '0;
      addr_r        <= '0;
      fin_r         <= 1'b0;
      lenfill_r     <= 1'b0;
      idx_r         <= '0;
      padded_once_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rnd_r         <= rnd_nxt;
      addr_r        <= addr_nxt;
      fin_r         <= fin_nxt;
      lenfill_r     <= lenfill_nxt;
      idx_r         <= idx_nxt;
      padded_once_r <= padded_once_nxt;
    end
  end

endmodule

[rtl/md5_dp.sv]
module md5_dp import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  md5_cmd_t    cmd,
  input  logic [1:0]  out_idx,
  output logic [31:0] out_word,
  output md5_sts_t    sts
);

  logic [31:0] buf_r [CHUNK_BYTES / 4];
  logic [63:0] cnt_r;
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;
  logic [63:0] bits;
  logic [7:0]  wdata;
  logic [31:0] m, f, sum, rot;
  logic [3:0]  g;
  logic [4:0]  s;

  assign sts.fill = cnt_r[5:0];
  assign bits     = {cnt_r[60:0], 3'b000};
  assign out_word = h_r[out_idx];

  always_comb begin
    case (cmd.wr_sel)
      BSEL_MSG:  wdata = in_byte;
      BSEL_PAD:  wdata = PAD_BYTE;
      BSEL_ZERO: wdata = 8'h00;
      BSEL_LEN:  wdata = bits[{cmd.wr_addr[2:0], 3'b000} +: 8];
      default:   wdata = 8'h00;
    endcase
  end

  assign g = round_g(rnd_r);
  assign s = round_s(rnd_r);
  assign m = buf_r[g];

  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign sum = a_r + f + round_k(rnd_r) + m;
  assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

  always_ff @(posedge clk) begin
    if (cmd.wr_en) buf_r[cmd.wr_addr[5:2]][{cmd.wr_addr[1:0], 3'b000} +: 8] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd_start) begin
      a_r   <= h_r[0];
      b_r   <= h_r[1];
      c_r   <= h_r[2];
      d_r   <= h_r[3];
      rnd_r <= '0;
    end else if (cmd.rnd_step) begin
      a_r   <= d_r;
      b_r   <= b_r + rot;
      c_r   <= b_r;
      d_r   <= c_r;
      rnd_r <= rnd_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      cnt_r  <= '0;
      h_r[0] <= H0_INIT;
      h_r[1] <= H1_INIT;
      h_r[2] <= H2_INIT;
      h_r[3] <= H3_INIT;
    end else begin
      if (cmd.cnt_inc) cnt_r <= cnt_r + 64'd1;
      if (cmd.rnd_finish) begin
        h_r[0] <= h_r[0] + d_r;
        h_r[1] <= h_r[1] + b_r + rot;
        h_r[2] <= h_r[2] + b_r;
        h_r[3] <= h_r[3] + c_r;
      end
    end
  end

endmodule

[rtl/md5_stream_hash.sv]
// Flow: a byte is taken while in_tready is high; a full chunk then runs its rounds
// on the single round unit. The closing beat adds the padding writes and one or two
// chunks of rounds, then four result beats, each held until out_tready.
// Throughput: one byte per cycle within a chunk; input is held off while the
// rounds of a chunk run.
// Reset: synchronous active-low rst_n restores the initial chain and a zero count.
module md5_stream_hash import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // message_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word, word_index, zero fill
  output logic        out_tlast   // last_word
);

  md5_cmd_t    cmd;
  md5_sts_t    sts;
  logic [1:0]  idx;
  logic [31:0] word;

  md5_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_has(in_tuser), .in_last(in_tlast),
    .out_tvalid, .out_tready, .out_idx(idx), .sts, .cmd
  );

  md5_dp u_dp (
    .clk, .rst_n, .in_byte(in_tdata), .cmd, .out_idx(idx),
    .out_word(word), .sts
  );

  assign out_tdata = {6'd0, idx, word};
  assign out_tlast = (idx == 2'd3);

  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input ready while output pending");
  a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && idx != 2'd3 |=> out_tvalid && idx == $past(idx) + 2'd1)
    else $error("word index did not advance");

endmodule
